@@ src/cpcb_pkg.sv @@
// Package for the cel pixel convert and blend block.
// Holds widths, codes, the rounded 8-bit multiply and shared structs.
// No dependencies.
package cpcb_pkg;

  localparam int PaletteDepth = 256;
  localparam int PalAddrW     = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;
  localparam int ColorW       = 32;
  localparam logic [15:0] RoundBias = 16'h0080;

  // configuration register indexes
  localparam logic [1:0] RegPixelMode  = 2'd0;
  localparam logic [1:0] RegCelAlpha   = 2'd1;
  localparam logic [1:0] RegLayerAlpha = 2'd2;

  // pixel modes
  localparam logic [1:0] ModeRgba    = 2'd0;
  localparam logic [1:0] ModeGray    = 2'd1;
  localparam logic [1:0] ModeIndexed = 2'd2;

  // operation codes
  localparam logic OpPalWrite = 1'b0;
  localparam logic OpBlend    = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // rounded product a*b/255
  function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, 16'(a) * 16'(b)} + {1'b0, RoundBias};
    u = {8'd0, t[16:8]} + t;
    return u[15:8];
  endfunction

endpackage

@@ src/cpcb_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module cpcb_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

@@ src/cpcb_div.sv @@
// One blend channel divide: q = diff*sa/ra truncated toward zero, as a
// restoring divide over 16 quotient bits unrolled into 16 registered stages.
// No dependencies.
module cpcb_div (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] num,     // |diff*sa|, at most 65025
  input  logic [7:0]  den,
  output logic [15:0] quo
);
  logic [15:0] n   [17];
  logic [8:0]  rem [17];
  logic [15:0] q   [17];
  logic [7:0]  d   [17];

  always_comb begin
    n[0] = num;
    rem[0] = 9'd0;
    q[0] = 16'd0;
    d[0] = den;
  end

  for (genvar i = 0; i < 16; i++) begin : g_stage
    logic [9:0] trial;
    assign trial = {rem[i], n[i][15]} - {2'b00, d[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        n[i+1] <= {n[i][14:0], 1'b0};
        d[i+1] <= d[i];
        if (!trial[9]) begin
          rem[i+1] <= trial[8:0];
          q[i+1]   <= {q[i][14:0], 1'b1};
        end else begin
          rem[i+1] <= {rem[i][7:0], n[i][15]};
          q[i+1]   <= {q[i][14:0], 1'b0};
        end
      end
    end
  end

  assign quo = q[16];
endmodule

@@ src/cel_pixel_convert_and_blend.sv @@
// Top level: palette RAM, source conversion and Porter-Duff over blend.
// Depends on cpcb_pkg, cpcb_ram, cpcb_div.
// Throughput one item per cycle while the output is not stalled.
// Palette read, three blend stages, 16 divide stages and the output register form the pipeline;
// the whole pipeline holds while the output register is full and not taken.
// Synchronous active-high reset: mode rgba, alphas 255; palette undefined until written.
module cel_pixel_convert_and_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[0], palette_index[8:1], palette_color[40:9], src_r..src_a[72:41],
  // dst_r..dst_a[104:73], zero fill to 111
  input  logic [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_r[7:0], out_g[15:8], out_b[23:16], out_a[31:24], changed[32], fill to 39
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int AW = cpcb_pkg::PalAddrW;

  logic [1:0] pixel_mode;
  logic [7:0] cel_alpha, layer_alpha;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= cpcb_pkg::ModeRgba;
      cel_alpha <= 8'd255;
      layer_alpha <= 8'd255;
    end else if (cfg_valid) begin
      case (cfg_index)
        cpcb_pkg::RegPixelMode:  pixel_mode <= cfg_data[1:0];
        cpcb_pkg::RegCelAlpha:   cel_alpha <= cfg_data;
        cpcb_pkg::RegLayerAlpha: layer_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  // input field unpack
  logic op;
  logic [7:0] pidx;
  logic [31:0] pcol;
  cpcb_pkg::rgba_t src_in, dst_in;
  assign op = s_axis_tdata[0];
  assign pidx = s_axis_tdata[8:1];
  assign pcol = s_axis_tdata[40:9];
  assign src_in = '{r: s_axis_tdata[48:41], g: s_axis_tdata[56:49],
                    b: s_axis_tdata[64:57], a: s_axis_tdata[72:65]};
  assign dst_in = '{r: s_axis_tdata[80:73], g: s_axis_tdata[88:81],
                    b: s_axis_tdata[96:89], a: s_axis_tdata[104:97]};

  // pipeline advance: output register free or draining
  logic adv;
  logic out_v;
  assign adv = !out_v || m_axis_tready;
  assign s_axis_tready = adv;

  logic acc;
  assign acc = s_axis_tvalid && adv;

  // palette memory
  logic [31:0] pal_rd;
  logic wr_ok, rd_ok;
  assign wr_ok = (32'(pidx) < 32'(cpcb_pkg::PaletteDepth));
  assign rd_ok = (32'(src_in.r) < 32'(cpcb_pkg::PaletteDepth));
  cpcb_ram #(.Width(cpcb_pkg::ColorW), .Depth(cpcb_pkg::PaletteDepth)) u_pal (
    .clk(clk),
    .we(acc && op == cpcb_pkg::OpPalWrite && wr_ok),
    .waddr(pidx[AW-1:0]),
    .wdata(pcol),
    .re(adv),
    .raddr(src_in.r[AW-1:0]),
    .rdata(pal_rd)
  );

  // stage 1: register item and mode
  logic s1_v, s1_pal, s1_ok;
  logic [1:0] s1_mode;
  cpcb_pkg::rgba_t s1_src, s1_dst;
  logic [7:0] s1_op8;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= acc && op == cpcb_pkg::OpBlend;
    if (adv) begin
      s1_mode <= pixel_mode;
      s1_ok <= rd_ok;
      s1_src <= src_in;
      s1_dst <= dst_in;
      s1_op8 <= cpcb_pkg::mul8(cel_alpha, layer_alpha);
    end
  end
  assign s1_pal = (s1_mode == cpcb_pkg::ModeIndexed);

  // source conversion
  cpcb_pkg::rgba_t cs;
  always_comb begin
    case (s1_mode)
      cpcb_pkg::ModeGray: cs = '{r: s1_src.r, g: s1_src.r, b: s1_src.r, a: s1_src.g};
      cpcb_pkg::ModeIndexed:
        cs = (s1_pal && s1_ok) ? '{r: pal_rd[7:0], g: pal_rd[15:8], b: pal_rd[23:16],
                                   a: pal_rd[31:24]} : '0;
      default: cs = s1_src;
    endcase
  end

  // stage 2: sa
  logic s2_v, s2_skip;
  cpcb_pkg::rgba_t s2_s, s2_d;
  logic [7:0] s2_sa;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
    if (adv) begin
      s2_s <= cs;
      s2_d <= s1_dst;
      s2_skip <= (s1_op8 == 8'd0) || (cs.a == 8'd0);
      s2_sa <= cpcb_pkg::mul8(cs.a, s1_op8);
    end
  end

  // stage 3: ra
  logic s3_v, s3_skip;
  cpcb_pkg::rgba_t s3_s, s3_d;
  logic [7:0] s3_sa, s3_ra;
  logic [7:0] ra_c;
  assign ra_c = s2_d.a + s2_sa - cpcb_pkg::mul8(s2_d.a, s2_sa);
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
    if (adv) begin
      s3_s <= s2_s;
      s3_d <= s2_d;
      s3_sa <= s2_sa;
      s3_ra <= ra_c;
      s3_skip <= s2_skip || (ra_c == 8'd0);
    end
  end

  // stage 4: signed products magnitude and sign
  logic s4_v, s4_skip;
  cpcb_pkg::rgba_t s4_d;
  logic [7:0] s4_ra;
  logic [15:0] s4_m [3];
  logic [2:0] s4_neg;
  logic [7:0] sv [3];
  logic [7:0] dv [3];
  assign sv[0] = s3_s.r; assign sv[1] = s3_s.g; assign sv[2] = s3_s.b;
  assign dv[0] = s3_d.r; assign dv[1] = s3_d.g; assign dv[2] = s3_d.b;
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
    if (adv) begin
      s4_d <= s3_d;
      s4_ra <= s3_ra;
      s4_skip <= s3_skip;
      for (int i = 0; i < 3; i++) begin
        s4_neg[i] <= sv[i] < dv[i];
        s4_m[i] <= 16'((sv[i] < dv[i]) ? (dv[i] - sv[i]) : (sv[i] - dv[i])) * 16'(s3_sa);
      end
    end
  end

  // divide pipeline, sideband delayed alongside
  logic [15:0] q [3];
  for (genvar c = 0; c < 3; c++) begin : g_div
    cpcb_div u_div (.clk(clk), .en(adv), .num(s4_m[c]), .den(s4_ra), .quo(q[c]));
  end

  logic dl_v [17];
  logic dl_skip [17];
  cpcb_pkg::rgba_t dl_d [17];
  logic [7:0] dl_ra [17];
  logic [2:0] dl_neg [17];
  always_comb begin
    dl_v[0] = s4_v; dl_skip[0] = s4_skip; dl_d[0] = s4_d;
    dl_ra[0] = s4_ra; dl_neg[0] = s4_neg;
  end
  for (genvar i = 0; i < 16; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) dl_v[i+1] <= 1'b0;
      else if (adv) dl_v[i+1] <= dl_v[i];
      if (adv) begin
        dl_skip[i+1] <= dl_skip[i];
        dl_d[i+1] <= dl_d[i];
        dl_ra[i+1] <= dl_ra[i];
        dl_neg[i+1] <= dl_neg[i];
      end
    end
  end

  // final add and output register
  logic [7:0] ch [3];
  logic [7:0] dd [3];
  assign dd[0] = dl_d[16].r; assign dd[1] = dl_d[16].g; assign dd[2] = dl_d[16].b;
  always_comb begin
    for (int i = 0; i < 3; i++)
      ch[i] = dl_neg[16][i] ? dd[i] - q[i][7:0] : dd[i] + q[i][7:0];
  end

  logic [32:0] out_d;
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (adv) out_v <= dl_v[16];
    if (adv) begin
      if (dl_skip[16])
        out_d <= {1'b0, dl_d[16].a, dl_d[16].b, dl_d[16].g, dl_d[16].r};
      else
        out_d <= {1'b1, dl_ra[16], ch[2], ch[1], ch[0]};
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata = {7'd0, out_d};
endmodule
